>>> hw/rtl/bbw_pkg.sv
// ----------------------------------------------------------------------------
// bbw_pkg
// Shared types and constants for the bandpass weight generator.
// ----------------------------------------------------------------------------
package bbw_pkg;

  localparam int MaxTapsDef = 63;

  localparam logic [31:0] RATIO_RESET = 32'h4000_0000;
  localparam logic [5:0]  KLEN_RESET  = 6'd31;

  localparam logic [31:0] ONE_Q28 = 32'h1000_0000;
  localparam logic [31:0] CK1     = 32'd3333107;
  localparam logic [31:0] CK2     = 32'd124319616;
  localparam logic [31:0] CK3     = 32'd834094232;
  localparam logic [31:0] CK4     = 32'd251972339;
  localparam logic [23:0] MAG_ONE = 24'h80_0000;

  localparam logic [5:0] DIV_STEPS  = 6'd46;
  localparam logic [5:0] ROOT_STEPS = 6'd23;

  localparam logic CFG_STEP_RATIO    = 1'b0;
  localparam logic CFG_KERNEL_LENGTH = 1'b1;

  typedef enum logic [3:0] {
    OP_P2     = 4'd0,
    OP_P3     = 4'd1,
    OP_P4     = 4'd2,
    OP_P5     = 4'd3,
    OP_P6     = 4'd4,
    OP_NUM    = 4'd5,
    OP_RE_POS = 4'd6,
    OP_RE_NEG = 4'd7,
    OP_IM_P1  = 4'd8,
    OP_IM_P5  = 4'd9,
    OP_IM_NEG = 4'd10
  } mul_op_e;

  typedef struct packed {
    logic       load_freq;
    logic       load_center;
    logic       mul_lo;
    logic       mul_hi;
    logic       mul_acc;
    mul_op_e    op;
    logic       combine;
    logic       norm_shift;
    logic       sq_a;
    logic       sq_b;
    logic       sq_n;
    logic       check;
    logic       div_step;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       freq_mul;
    logic       freq_upd;
    logic       out_load;
    logic [5:0] out_tap;
    logic       out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic norm_done;
    logic d_zero;
    logic gain_high;
  } dp_status_t;

endpackage

>>> hw/rtl/bbw_in_if.sv
// ----------------------------------------------------------------------------
// bbw_in_if
// Input channel: action and frequency.
// ----------------------------------------------------------------------------
interface bbw_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] freq;

  modport source (output valid, output action, output freq, input ready);
  modport sink   (input valid, input action, input freq, output ready);
endinterface

>>> hw/rtl/bbw_out_if.sv
// ----------------------------------------------------------------------------
// bbw_out_if
// Output channel: magnitude, tap index and last flag.
// ----------------------------------------------------------------------------
interface bbw_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] magnitude;
  logic [5:0]  tap_index;
  logic        last;

  modport source (output valid, output magnitude, output tap_index, output last,
                  input ready);
  modport sink   (input valid, input magnitude, input tap_index, input last,
                  output ready);
endinterface

>>> hw/rtl/bbw_datapath.sv
// ----------------------------------------------------------------------------
// bbw_datapath
// Polynomial evaluation, normalization, division, root and result register.
// ----------------------------------------------------------------------------
module bbw_datapath (
  input  logic               clk_i,
  input  logic [31:0]        freq_i,
  input  logic [31:0]        step_ratio_i,
  input  bbw_pkg::ctrl_cmd_t cmd_i,
  output bbw_pkg::dp_status_t status_o,
  output logic [23:0]        magnitude_o,
  output logic [5:0]         tap_index_o,
  output logic               last_o
);
  import bbw_pkg::*;

  logic [31:0] f_q;
  logic [63:0] p1, p2_q, p3_q, p4_q, p5_q, p6_q;
  logic [63:0] pl_q, ph_q;
  logic [63:0] n_q, rep_q, ren_q, imp_q, imn_q;
  logic [63:0] a_q, b_q;
  logic [63:0] d_q;
  logic [61:0] nn_q;
  logic [63:0] rem_q;
  logic [45:0] quo_q;
  logic [45:0] x_q, r_q, bit_q;
  logic [63:0] fprod_q;
  logic        special_q;
  logic [23:0] spec_mag_q;
  logic [23:0] mag_q;
  logic [5:0]  tap_q;
  logic        last_q;

  logic [63:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] mul_half;
  logic [63:0] mul_prod;
  logic [95:0] acc_sum;
  logic [63:0] mul_res;
  logic [63:0] or_all;
  logic [30:0] sq_x;
  logic [61:0] sq_prod;
  logic [64:0] div_r2;
  logic        div_ge;
  logic [46:0] rt_sum;
  logic        rt_ge;
  logic [64:0] fq_sum;
  logic [34:0] fq_sh;
  logic [23:0] mag_now;

  assign p1 = {32'd0, f_q};

  always_comb begin
    mul_a = p1;
    mul_b = f_q;
    case (cmd_i.op)
      OP_P2:     begin mul_a = p1;   mul_b = f_q; end
      OP_P3:     begin mul_a = p2_q; mul_b = f_q; end
      OP_P4:     begin mul_a = p3_q; mul_b = f_q; end
      OP_P5:     begin mul_a = p4_q; mul_b = f_q; end
      OP_P6:     begin mul_a = p5_q; mul_b = f_q; end
      OP_NUM:    begin mul_a = p3_q; mul_b = CK1; end
      OP_RE_POS: begin mul_a = p4_q; mul_b = CK3; end
      OP_RE_NEG: begin mul_a = p2_q; mul_b = CK3; end
      OP_IM_P1:  begin mul_a = p1;   mul_b = CK2; end
      OP_IM_P5:  begin mul_a = p5_q; mul_b = CK2; end
      OP_IM_NEG: begin mul_a = p3_q; mul_b = CK4; end
      default:   begin mul_a = p1;   mul_b = f_q; end
    endcase
  end

  assign mul_half = cmd_i.mul_hi ? mul_a[63:32] : mul_a[31:0];
  assign mul_prod = {32'd0, mul_half} * {32'd0, mul_b};
  assign acc_sum  = {32'd0, pl_q} + {ph_q, 32'd0} + 96'h800_0000;
  assign mul_res  = acc_sum[91:28];

  assign or_all = n_q | a_q | b_q;

  always_comb begin
    sq_x = a_q[30:0];
    if (cmd_i.sq_b) begin
      sq_x = b_q[30:0];
    end else if (cmd_i.sq_n) begin
      sq_x = n_q[30:0];
    end
  end
  assign sq_prod = {31'd0, sq_x} * {31'd0, sq_x};

  assign div_r2 = {rem_q, 1'b0};
  assign div_ge = div_r2 >= {1'b0, d_q};

  assign rt_sum = {1'b0, r_q} + {1'b0, bit_q};
  assign rt_ge  = {1'b0, x_q} >= rt_sum;

  assign fq_sum = {1'b0, fprod_q} + 65'h2000_0000;
  assign fq_sh  = fq_sum[64:30];

  assign mag_now = special_q ? spec_mag_q : r_q[23:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_freq) begin
      f_q <= freq_i;
    end else if (cmd_i.load_center) begin
      f_q <= ONE_Q28;
    end else if (cmd_i.freq_upd) begin
      f_q <= (fq_sh > 35'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : fq_sh[31:0];
    end
    if (cmd_i.freq_mul) begin
      fprod_q <= {32'd0, f_q} * {32'd0, step_ratio_i};
    end
    if (cmd_i.mul_lo) begin
      pl_q <= mul_prod;
    end
    if (cmd_i.mul_hi) begin
      ph_q <= mul_prod;
    end
    if (cmd_i.mul_acc) begin
      case (cmd_i.op)
        OP_P2:     p2_q  <= mul_res;
        OP_P3:     p3_q  <= mul_res;
        OP_P4:     p4_q  <= mul_res;
        OP_P5:     p5_q  <= mul_res;
        OP_P6:     p6_q  <= mul_res;
        OP_NUM:    n_q   <= mul_res;
        OP_RE_POS: rep_q <= mul_res + {32'd0, ONE_Q28};
        OP_RE_NEG: ren_q <= mul_res + p6_q;
        OP_IM_P1:  imp_q <= mul_res;
        OP_IM_P5:  imp_q <= imp_q + mul_res;
        OP_IM_NEG: imn_q <= mul_res;
        default:   p2_q  <= mul_res;
      endcase
    end
    if (cmd_i.combine) begin
      a_q <= (rep_q >= ren_q) ? rep_q - ren_q : ren_q - rep_q;
      b_q <= (imp_q >= imn_q) ? imp_q - imn_q : imn_q - imp_q;
    end else if (cmd_i.norm_shift) begin
      n_q <= n_q >> 1;
      a_q <= a_q >> 1;
      b_q <= b_q >> 1;
    end
    if (cmd_i.sq_a) begin
      d_q <= {2'd0, sq_prod};
    end else if (cmd_i.sq_b) begin
      d_q <= d_q + {2'd0, sq_prod};
    end
    if (cmd_i.sq_n) begin
      nn_q <= sq_prod;
    end
    if (cmd_i.check) begin
      special_q  <= status_o.d_zero || status_o.gain_high;
      spec_mag_q <= (status_o.d_zero && (n_q == 64'd0)) ? 24'd0 : MAG_ONE;
      rem_q      <= {2'd0, nn_q};
      quo_q      <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? 64'(div_r2 - {1'b0, d_q}) : div_r2[63:0];
      quo_q <= {quo_q[44:0], div_ge};
    end
    if (cmd_i.sqrt_init) begin
      x_q   <= quo_q;
      r_q   <= '0;
      bit_q <= 46'h1 << 44;
    end else if (cmd_i.sqrt_step) begin
      if (rt_ge) begin
        x_q <= 46'({1'b0, x_q} - rt_sum);
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.out_load) begin
      mag_q  <= mag_now;
      tap_q  <= cmd_i.out_tap;
      last_q <= cmd_i.out_last;
    end
  end

  assign status_o.norm_done = (or_all[63:31] == 33'd0);
  assign status_o.d_zero    = (d_q == 64'd0);
  assign status_o.gain_high = ({2'd0, nn_q} >= d_q);

  assign magnitude_o = mag_q;
  assign tap_index_o = tap_q;
  assign last_o      = last_q;

endmodule

>>> hw/rtl/bbw_ctrl.sv
// ----------------------------------------------------------------------------
// bbw_ctrl
// Sequencer for one magnitude evaluation and for the kernel tap walk.
// ----------------------------------------------------------------------------
module bbw_ctrl #(
  parameter int MAX_TAPS = bbw_pkg::MaxTapsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_action_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  logic [5:0]          kernel_length_i,
  input  bbw_pkg::dp_status_t status_i,
  output bbw_pkg::ctrl_cmd_t  cmd_o
);
  import bbw_pkg::*;

  localparam int HalfCapInt = (MAX_TAPS - 1) / 2;
  localparam logic [4:0] HALF_CAP = (HalfCapInt > 31) ? 5'd31 : 5'(HalfCapInt);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_MULLO = 17'h00002,
    S_MULHI = 17'h00004,
    S_ACC   = 17'h00008,
    S_COMB  = 17'h00010,
    S_NORM  = 17'h00020,
    S_SQA   = 17'h00040,
    S_SQB   = 17'h00080,
    S_SQN   = 17'h00100,
    S_CHECK = 17'h00200,
    S_DIV   = 17'h00400,
    S_SQI   = 17'h00800,
    S_SQRT  = 17'h01000,
    S_OUT1  = 17'h02000,
    S_OUT2  = 17'h04000,
    S_FMUL  = 17'h08000,
    S_FUPD  = 17'h10000
  } state_e;

  state_e     state_q, state_d;
  mul_op_e    op_q, op_d;
  logic [5:0] cnt_q, cnt_d;
  logic [4:0] half_q, half_d;
  logic [4:0] idx_q, idx_d;
  logic       kernel_q, kernel_d;
  logic       out_valid_q, out_valid_d;
  logic [4:0] half_in;
  logic       out_free;

  assign half_in  = (kernel_length_i[5:1] > HALF_CAP) ? HALF_CAP : kernel_length_i[5:1];
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    cnt_d    = cnt_q;
    half_d   = half_q;
    idx_d    = idx_q;
    kernel_d = kernel_q;
    cmd_o    = '0;
    cmd_o.op = op_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_action_i) begin
            kernel_d          = 1'b1;
            half_d            = half_in;
            idx_d             = '0;
            cmd_o.load_center = 1'b1;
          end else begin
            kernel_d        = 1'b0;
            cmd_o.load_freq = 1'b1;
          end
          op_d    = OP_P2;
          state_d = S_MULLO;
        end
      end
      S_MULLO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = S_MULHI;
      end
      S_MULHI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        cmd_o.mul_acc = 1'b1;
        if (op_q == OP_IM_NEG) begin
          state_d = S_COMB;
        end else begin
          op_d    = mul_op_e'(op_q + 4'd1);
          state_d = S_MULLO;
        end
      end
      S_COMB: begin
        cmd_o.combine = 1'b1;
        state_d       = S_NORM;
      end
      S_NORM: begin
        if (status_i.norm_done) begin
          state_d = S_SQA;
        end else begin
          cmd_o.norm_shift = 1'b1;
        end
      end
      S_SQA: begin
        cmd_o.sq_a = 1'b1;
        state_d    = S_SQB;
      end
      S_SQB: begin
        cmd_o.sq_b = 1'b1;
        state_d    = S_SQN;
      end
      S_SQN: begin
        cmd_o.sq_n = 1'b1;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        cnt_d       = '0;
        state_d     = (status_i.d_zero || status_i.gain_high) ? S_OUT1 : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 6'd1;
        if (cnt_q == DIV_STEPS - 6'd1) begin
          state_d = S_SQI;
        end
      end
      S_SQI: begin
        cmd_o.sqrt_init = 1'b1;
        cnt_d           = '0;
        state_d         = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + 6'd1;
        if (cnt_q == ROOT_STEPS - 6'd1) begin
          state_d = S_OUT1;
        end
      end
      S_OUT1: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          if (!kernel_q) begin
            cmd_o.out_tap  = '0;
            cmd_o.out_last = 1'b1;
            state_d        = S_IDLE;
          end else if (idx_q == 5'd0) begin
            cmd_o.out_tap  = {1'b0, half_q};
            cmd_o.out_last = (half_q == 5'd0);
            state_d        = (half_q == 5'd0) ? S_IDLE : S_FMUL;
          end else begin
            cmd_o.out_tap  = {1'b0, half_q} + {1'b0, idx_q};
            cmd_o.out_last = 1'b0;
            state_d        = S_OUT2;
          end
        end
      end
      S_OUT2: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_tap  = {1'b0, half_q} - {1'b0, idx_q};
          cmd_o.out_last = (idx_q == half_q);
          state_d        = (idx_q == half_q) ? S_IDLE : S_FMUL;
        end
      end
      S_FMUL: begin
        cmd_o.freq_mul = 1'b1;
        idx_d          = idx_q + 5'd1;
        state_d        = S_FUPD;
      end
      S_FUPD: begin
        cmd_o.freq_upd = 1'b1;
        op_d           = OP_P2;
        state_d        = S_MULLO;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_P2;
      cnt_q       <= '0;
      half_q      <= '0;
      idx_q       <= '0;
      kernel_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      half_q      <= half_d;
      idx_q       <= idx_d;
      kernel_q    <= kernel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/butterworth_bandpass_weights.sv
// ----------------------------------------------------------------------------
// butterworth_bandpass_weights
// Six-pole third-octave bandpass magnitude and symmetric kernel weights.
//
//   channel  dir  handshake      payload
//   in_if    in   valid/ready    action, freq
//   out_if   out  valid/ready    magnitude, tap_index, last
//   cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// A magnitude evaluation runs in order: the polynomial terms in the shared 32x32
// multiplier, the combine, normalization shifts, squares and checks, 46 divider
// steps, the root and the output load. A zero denominator or a gain at or above
// unity skips divider and root. Each kernel tap pair adds the frequency step and
// the mirrored tap. Reset is asynchronous, active low, and leaves the block idle.
// A stalled output holds the sequencer before it loads the next result.
// ----------------------------------------------------------------------------
module butterworth_bandpass_weights #(
  parameter int MAX_TAPS = bbw_pkg::MaxTapsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bbw_in_if.sink      in_if,
  bbw_out_if.source   out_if,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import bbw_pkg::*;

  logic [31:0] step_ratio_q;
  logic [5:0]  kernel_length_q;
  ctrl_cmd_t   cmd;
  dp_status_t  status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_ratio_q    <= RATIO_RESET;
      kernel_length_q <= KLEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STEP_RATIO:    step_ratio_q    <= cfg_data_i;
        CFG_KERNEL_LENGTH: kernel_length_q <= cfg_data_i[5:0];
        default:           step_ratio_q    <= step_ratio_q;
      endcase
    end
  end

  bbw_ctrl #(
    .MAX_TAPS(MAX_TAPS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_if.valid),
    .in_action_i    (in_if.action),
    .in_ready_o     (in_if.ready),
    .out_valid_o    (out_if.valid),
    .out_ready_i    (out_if.ready),
    .kernel_length_i(kernel_length_q),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  bbw_datapath u_dp (
    .clk_i       (clk_i),
    .freq_i      (in_if.freq),
    .step_ratio_i(step_ratio_q),
    .cmd_i       (cmd),
    .status_o    (status),
    .magnitude_o (out_if.magnitude),
    .tap_index_o (out_if.tap_index),
    .last_o      (out_if.last)
  );

endmodule

>>> hw/rtl/bbw_checker.sv
// ----------------------------------------------------------------------------
// bbw_checker
// Port-level checks for the bandpass weight generator.
// ----------------------------------------------------------------------------
module bbw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] magnitude,
  input logic [5:0]  tap_index,
  input logic        last
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(magnitude) &&
      $stable(tap_index) && $stable(last))
    else $error("output transaction changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while evaluation in progress");

  a_mag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> magnitude <= 24'h80_0000)
    else $error("magnitude above unity");

  a_no_out_at_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> ##1 !(out_valid && $rose(out_valid) && !in_ready &&
      $past(in_ready, 2)))
    else $error("result produced too soon after accept");

endmodule

bind butterworth_bandpass_weights bbw_checker u_bbw_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_valid (in_if.valid),
  .in_ready (in_if.ready),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .magnitude(out_if.magnitude),
  .tap_index(out_if.tap_index),
  .last     (out_if.last)
);
